@@ src/cdsw_pkg.sv @@
`default_nettype none

package cdsw_pkg;

  // field widths
  localparam int YEAR_W = 14;
  localparam int DAY_W  = 9;
  localparam int CNT_W  = 6;

  // largest number of Saturdays listed for one word
  localparam int MAX_COUNT = 63;

  // reciprocal constants: floor(x/100) = (x*RECIP_100) >> SHIFT_100 for x < 2^14,
  // x/7 = (x*RECIP_7) >> SHIFT_7 is floor or floor-1 for x < 2^15
  localparam int RECIP_100 = 5243;
  localparam int SHIFT_100 = 19;
  localparam int RECIP_7   = 9362;
  localparam int SHIFT_7   = 16;

  localparam logic [2:0] SATURDAY = 3'd6;

  typedef enum logic [1:0] {
    KIND_DATE    = 2'd0,
    KIND_SAT     = 2'd1,
    KIND_NOMORE  = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [DAY_W-1:0]  day_of_year;
    logic [CNT_W-1:0]  saturday_count;
  } cdsw_in_t;

  typedef struct packed {
    kind_t             kind;
    logic [2:0]        weekday;
    logic [3:0]        month;
    logic [4:0]        month_day;
    logic [YEAR_W-1:0] result_year;
    logic              last;
  } cdsw_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUO,
    ST_SUM,
    ST_PROD,
    ST_WDAY,
    ST_FIRST,
    ST_WALK
  } cdsw_state_t;

  // controller -> datapath
  typedef struct packed {
    logic  load;
    logic  q_en;
    logic  v_en;
    logic  p_en;
    logic  wd_en;
    logic  emit;
    kind_t kind;
    logic  last;
    logic  walk_init;
    logic  walk_step;
  } cdsw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic invalid;
    logic cnt_zero;
    logic past_end;
    logic rem_one;
  } cdsw_sts_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] md;
  } cdsw_loc_t;

  // last day number of each month in a common year
  localparam logic [DAY_W-1:0] MONTH_END [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  // month and day of month; zeros when day is past the year
  function automatic cdsw_loc_t cdsw_locate(input logic [DAY_W-1:0] day, input logic leap);
    cdsw_loc_t        r;
    logic [DAY_W-1:0] e;
    logic [DAY_W-1:0] ep;
    r = '0;
    // descending so the earliest matching month wins
    for (int m = 12; m >= 1; m--) begin
      e  = MONTH_END[m] + ((leap && m >= 2) ? 9'd1 : 9'd0);
      ep = MONTH_END[m-1] + ((leap && m >= 3) ? 9'd1 : 9'd0);
      if (day <= e) begin
        r.month = 4'(m);
        r.md    = 5'(day - ep);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/calendar_date_and_saturday_walker.sv @@
// The result strobe is registered from state FIRST, after the 4-step weekday computation
// in QUO, SUM, PROD and WDAY, then one result per cycle; a word gives N results (1..55).
// Busy, high from the accepting edge until the final result is registered, blocks new words.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Reset: synchronous active-low rst_n returns the controller to idle and clears out_valid.
`default_nettype none

module calendar_date_and_saturday_walker
  import cdsw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire cdsw_in_t in_word,
  output logic          out_valid,
  output cdsw_out_t     out_word
);

  cdsw_cmd_t cmd;
  cdsw_sts_t sts;

  cdsw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  cdsw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // a result only follows a busy cycle
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work in progress");

  // an accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // the final result frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last) |-> !busy)
    else $error("busy after final result");

  // Saturday results carry weekday six
  a_sat_weekday: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.kind == KIND_SAT)) |-> (out_word.weekday == SATURDAY))
    else $error("Saturday result with wrong weekday");

endmodule

`default_nettype wire

@@ src/cdsw_ctrl.sv @@
`default_nettype none

module cdsw_ctrl
  import cdsw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire cdsw_sts_t sts,
  output cdsw_cmd_t      cmd,
  output logic           busy
);

  cdsw_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_QUO;
      ST_QUO:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_PROD;
      ST_PROD:  state_nxt = ST_WDAY;
      ST_WDAY:  state_nxt = ST_FIRST;
      ST_FIRST: state_nxt = (sts.invalid || sts.cnt_zero) ? ST_IDLE : ST_WALK;
      ST_WALK:  if (sts.past_end || sts.rem_one) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_QUO:  cmd.q_en  = 1'b1;
      ST_SUM:  cmd.v_en  = 1'b1;
      ST_PROD: cmd.p_en  = 1'b1;
      ST_WDAY: cmd.wd_en = 1'b1;
      ST_FIRST: begin
        cmd.emit      = 1'b1;
        cmd.kind      = sts.invalid ? KIND_INVALID : KIND_DATE;
        cmd.last      = sts.invalid || sts.cnt_zero;
        cmd.walk_init = 1'b1;
      end
      ST_WALK: begin
        cmd.emit      = 1'b1;
        cmd.kind      = sts.past_end ? KIND_NOMORE : KIND_SAT;
        cmd.last      = sts.past_end || sts.rem_one;
        cmd.walk_step = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/cdsw_dp.sv @@
`default_nettype none

module cdsw_dp
  import cdsw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cdsw_in_t  in_word,
  input  wire cdsw_cmd_t cmd,
  output cdsw_sts_t      sts,
  output logic           out_valid,
  output cdsw_out_t      out_word
);

  logic [YEAR_W-1:0] year_r;
  logic [DAY_W-1:0]  cur_day_r;
  logic [CNT_W-1:0]  rem_r;
  logic [7:0]        q_year_r;
  logic [7:0]        q_y1_r;
  logic              leap_r;
  logic [14:0]       v_r;
  logic [28:0]       p_r;
  logic              invalid_r;
  logic [2:0]        wd_r;
  cdsw_out_t         out_r;
  logic              out_valid_r;

  logic [YEAR_W-1:0] y1;
  logic [26:0]       prod_year;
  logic [26:0]       prod_y1;
  logic [YEAR_W-1:0] r100;
  logic              leap_nxt;
  logic [14:0]       v_nxt;
  logic [14:0]       r7;
  logic [3:0]        r7_lo;
  logic [DAY_W-1:0]  year_len;
  logic [2:0]        offset;
  logic [CNT_W-1:0]  cnt_clamped;
  cdsw_loc_t         loc;
  cdsw_out_t         res_nxt;

  assign y1 = year_r - YEAR_W'(1);

  // quotients by 100 through reciprocal multiply
  assign prod_year = 27'(year_r) * 27'(RECIP_100);
  assign prod_y1   = 27'(y1) * 27'(RECIP_100);

  // leap rule: by 4, and not by 100 unless by 400
  assign r100     = year_r - (YEAR_W'(q_year_r) * YEAR_W'(100));
  assign leap_nxt = (year_r[1:0] == 2'b00) && ((r100 != '0) || (q_year_r[1:0] == 2'b00));

  // weekday sum; 365 is 1 mod 7 so each year adds one
  assign v_nxt = 15'(y1) + 15'(y1 >> 2) - 15'(q_y1_r) + 15'(q_y1_r >> 2)
               + 15'(cur_day_r);

  // remainder by 7 with one correction step
  assign r7    = v_r - (15'(p_r[28:SHIFT_7]) * 15'd7);
  assign r7_lo = (r7[3:0] >= 4'd7) ? (r7[3:0] - 4'd7) : r7[3:0];

  assign year_len    = leap_r ? 9'd366 : 9'd365;
  assign offset      = (wd_r == SATURDAY) ? 3'd7 : (SATURDAY - wd_r);
  assign cnt_clamped = (int'(in_word.saturday_count) > MAX_COUNT) ? CNT_W'(MAX_COUNT)
                                                                  : in_word.saturday_count;

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year_r    <= in_word.year;
      cur_day_r <= in_word.day_of_year;
      rem_r     <= cnt_clamped;
    end
    if (cmd.q_en) begin
      q_year_r <= prod_year[26:SHIFT_100];
      q_y1_r   <= prod_y1[26:SHIFT_100];
    end
    if (cmd.v_en) begin
      leap_r <= leap_nxt;
      v_r    <= v_nxt;
    end
    if (cmd.p_en) begin
      p_r       <= 29'(v_r) * 29'(RECIP_7);
      invalid_r <= (year_r == '0) || (cur_day_r == '0) || (cur_day_r > year_len);
    end
    if (cmd.wd_en) begin
      wd_r <= r7_lo[2:0];
    end
    // walk to the first Saturday after the input day, then week by week
    if (cmd.walk_init) begin
      cur_day_r <= cur_day_r + DAY_W'(offset);
    end else if (cmd.walk_step) begin
      cur_day_r <= cur_day_r + DAY_W'(7);
      rem_r     <= rem_r - CNT_W'(1);
    end
  end

  // result word
  always_comb begin
    loc                 = cdsw_locate(cur_day_r, leap_r);
    res_nxt             = '0;
    res_nxt.kind        = cmd.kind;
    res_nxt.result_year = year_r;
    res_nxt.last        = cmd.last;
    case (cmd.kind)
      KIND_DATE: begin
        res_nxt.weekday   = wd_r;
        res_nxt.month     = loc.month;
        res_nxt.month_day = loc.md;
      end
      KIND_SAT: begin
        res_nxt.weekday   = SATURDAY;
        res_nxt.month     = loc.month;
        res_nxt.month_day = loc.md;
      end
      default: begin
        res_nxt.weekday   = '0;
        res_nxt.month     = '0;
        res_nxt.month_day = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // status
  assign sts.invalid  = invalid_r;
  assign sts.cnt_zero = (rem_r == '0);
  assign sts.past_end = (cur_day_r > year_len);
  assign sts.rem_one  = (rem_r == CNT_W'(1));

endmodule

`default_nettype wire
